// ===== design/flow_sensor_frame_decode_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Flow sensor frame decode assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FLOW_SENSOR_FRAME_DECODE_UNIT_DEFINES_SVH
`define FLOW_SENSOR_FRAME_DECODE_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define FSFD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flow sensor frame decode: same-cycle check failed");
// next-cycle implication
`define FSFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flow sensor frame decode: next-cycle check failed");
`else
`define FSFD_ASSERT_SAME(label, clk, rst, ante, cons)
`define FSFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/fsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Flow sensor frame decode package
// Widths, constants, CRC-8 byte update and the divider control bundle.
// ----------------------------------------------------------------------------
package fsfd_pkg;

   localparam int ScaleW           = 14;
   localparam int RawW             = 16;
   localparam int MagW             = 16;
   localparam int GainW            = 10;
   localparam int DvdW             = 25;
   localparam int FlowW            = 20;
   localparam int CsrAddrW         = 3;
   localparam int CsrDataW         = 32;
   localparam int DivStepsPerStage = 5;
   localparam int DivStages        = DvdW / DivStepsPerStage;

   localparam logic [ScaleW-1:0] ScaleMin      = 14'd100;
   localparam logic [ScaleW-1:0] OxyScaleReset = 14'd1428;
   localparam logic [ScaleW-1:0] AirScaleReset = 14'd1400;
   localparam logic [RawW:0]     RawOffset     = 17'd32000;
   localparam logic [GainW-1:0]  FlowGain      = 10'd1000;
   localparam logic [7:0]        CrcPoly       = 8'h31;

   typedef enum logic {
      RegOxygenScale = 1'b0,
      RegAirScale    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic channel;
      logic negative;
      logic force_zero;
      logic crc_error;
   } div_ctl_type;

   // CRC-8, poly 0x31, MSB first, one byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      acc = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if (acc[7]) begin
            acc = {acc[6:0], 1'b0} ^ CrcPoly;
         end else begin
            acc = {acc[6:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

// ===== design/fsfd_div_stage.sv =====
// ----------------------------------------------------------------------------
// Divider pipeline stage
// Restoring unsigned division, several quotient bits per stage, registered.
// ----------------------------------------------------------------------------
module fsfd_div_stage #(
   parameter int STEPS = fsfd_pkg::DivStepsPerStage
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fsfd_pkg::div_ctl_type         ctl_i,
   input  logic [fsfd_pkg::ScaleW-1:0]   rem_i,
   input  logic [fsfd_pkg::DvdW-1:0]     work_i,
   input  logic [fsfd_pkg::ScaleW-1:0]   divisor_i,
   output fsfd_pkg::div_ctl_type         ctl_o,
   output logic [fsfd_pkg::ScaleW-1:0]   rem_o,
   output logic [fsfd_pkg::DvdW-1:0]     work_o,
   output logic [fsfd_pkg::ScaleW-1:0]   divisor_o
);
   import fsfd_pkg::*;

   div_ctl_type       ctl_ff;
   logic [ScaleW-1:0] rem_ff, rem_in;
   logic [DvdW-1:0]   work_ff, work_in;
   logic [ScaleW-1:0] div_ff;

   // work shifts dividend bits out the top and quotient bits in at the bottom
   always_comb begin : div_steps
      logic [ScaleW:0] trial;
      rem_in  = rem_i;
      work_in = work_i;
      for (int s = 0; s < STEPS; s++) begin
         trial   = {rem_in, work_in[DvdW-1]};
         work_in = {work_in[DvdW-2:0], 1'b0};
         if (trial >= {1'b0, divisor_i}) begin
            trial      = trial - {1'b0, divisor_i};
            work_in[0] = 1'b1;
         end
         rem_in = trial[ScaleW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
      rem_ff  <= rem_in;
      work_ff <= work_in;
      div_ff  <= divisor_i;
   end

   assign ctl_o     = ctl_ff;
   assign rem_o     = rem_ff;
   assign work_o    = work_ff;
   assign divisor_o = div_ff;

endmodule

// ===== design/flow_sensor_frame_decode_unit.sv =====
// A result strobes after the accepted frame has passed through each pipeline register below.
// Throughput: one frame per cycle; busy is low except during reset.
// Pipeline: capture, CRC high byte, CRC low byte and x1000 product, five
// divider stages of five quotient bits each, output register.
// Reset (synchronous) empties the pipeline and reloads both scale registers.
// ----------------------------------------------------------------------------
// Flow sensor frame decode unit
// Checks the CRC-8 of a sensor frame and converts the raw word to flow.
// ----------------------------------------------------------------------------
`include "flow_sensor_frame_decode_unit_defines.svh"

module flow_sensor_frame_decode_unit (
   input  logic                            clock,
   input  logic                            reset,
   // frame input
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_channel,
   input  logic [7:0]                      req_flow_high,
   input  logic [7:0]                      req_flow_low,
   input  logic [7:0]                      req_crc_byte,
   // result output
   output logic                            rsp_strobe,
   output logic                            rsp_result_channel,
   output logic signed [fsfd_pkg::FlowW-1:0] rsp_flow_hundredths,
   output logic                            rsp_crc_error,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fsfd_pkg::CsrAddrW-1:0]   paddr,
   input  logic [fsfd_pkg::CsrDataW-1:0]   pwdata,
   output logic [fsfd_pkg::CsrDataW-1:0]   prdata,
   output logic                            pready
);
   import fsfd_pkg::*;

   // ---------------- registers
   logic [ScaleW-1:0] oxy_scale_ff, air_scale_ff;
   logic              csr_wr;
   logic [ScaleW-1:0] rd_scale;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         oxy_scale_ff <= OxyScaleReset;
         air_scale_ff <= AirScaleReset;
      end else if (csr_wr) begin
         case (csr_index_type'(paddr[2]))
            RegOxygenScale: oxy_scale_ff <= pwdata[ScaleW-1:0];
            RegAirScale:    air_scale_ff <= pwdata[ScaleW-1:0];
            default: ;
         endcase
      end
   end

   assign rd_scale = (csr_index_type'(paddr[2]) == RegAirScale) ? air_scale_ff : oxy_scale_ff;
   assign prdata   = (paddr[1:0] != 2'b00) ? '0
                                           : {{(CsrDataW-ScaleW){1'b0}}, rd_scale};

   // ---------------- stage A: capture
   logic              accept;
   logic [ScaleW-1:0] sel_scale, a_scale_in;
   logic              a_valid_ff, a_ch_ff;
   logic [7:0]        a_hi_ff, a_lo_ff, a_rx_ff;
   logic [ScaleW-1:0] a_scale_ff;

   assign busy      = reset;
   assign accept    = start && !busy;
   assign sel_scale = req_channel ? air_scale_ff : oxy_scale_ff;
   assign a_scale_in = (sel_scale < ScaleMin) ? ScaleMin : sel_scale;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      a_ch_ff    <= req_channel;
      a_hi_ff    <= req_flow_high;
      a_lo_ff    <= req_flow_low;
      a_rx_ff    <= req_crc_byte;
      a_scale_ff <= a_scale_in;
   end

   // ---------------- stage B: CRC of high byte, offset and magnitude
   logic [RawW-1:0]   raw;
   logic [RawW:0]     diff;
   logic [RawW:0]     diff_abs;
   logic              b_valid_ff, b_ch_ff, b_neg_ff, b_nz_ff;
   logic [7:0]        b_crc_ff, b_lo_ff, b_rx_ff;
   logic [MagW-1:0]   b_mag_ff;
   logic [ScaleW-1:0] b_scale_ff;

   assign raw      = {a_hi_ff, a_lo_ff};
   assign diff     = {1'b0, raw} - RawOffset;
   assign diff_abs = diff[RawW] ? (~diff + 1'b1) : diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_ch_ff    <= a_ch_ff;
      b_crc_ff   <= crc8_byte(8'h00, a_hi_ff);
      b_lo_ff    <= a_lo_ff;
      b_rx_ff    <= a_rx_ff;
      b_neg_ff   <= diff[RawW];
      b_mag_ff   <= diff_abs[MagW-1:0];
      b_nz_ff    <= (raw != '0);
      b_scale_ff <= a_scale_ff;
   end

   // ---------------- stage C: CRC of low byte, scale by 1000
   logic [7:0]            crc_full;
   logic                  crc_bad;
   logic [MagW+GainW-1:0] prod;
   div_ctl_type           c_ctl_in, c_ctl_ff;
   logic [DvdW-1:0]       c_prod_ff;
   logic [ScaleW-1:0]     c_scale_ff;

   assign crc_full = crc8_byte(b_crc_ff, b_lo_ff);
   assign crc_bad  = (crc_full != b_rx_ff);
   assign prod     = b_mag_ff * FlowGain;

   always_comb begin
      c_ctl_in.valid      = b_valid_ff;
      c_ctl_in.channel    = b_ch_ff;
      c_ctl_in.negative   = b_neg_ff;
      c_ctl_in.force_zero = crc_bad || !b_nz_ff;
      c_ctl_in.crc_error  = crc_bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctl_ff <= '0;
      end else begin
         c_ctl_ff <= c_ctl_in;
      end
      c_prod_ff  <= prod[DvdW-1:0];
      c_scale_ff <= b_scale_ff;
   end

   // ---------------- divider pipeline
   div_ctl_type       dv_ctl   [0:DivStages];
   logic [ScaleW-1:0] dv_rem   [0:DivStages];
   logic [DvdW-1:0]   dv_work  [0:DivStages];
   logic [ScaleW-1:0] dv_div   [0:DivStages];

   assign dv_ctl[0]  = c_ctl_ff;
   assign dv_rem[0]  = '0;
   assign dv_work[0] = c_prod_ff;
   assign dv_div[0]  = c_scale_ff;

   for (genvar g = 0; g < DivStages; g++) begin : g_div
      fsfd_div_stage #(
         .STEPS(DivStepsPerStage)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .ctl_i     (dv_ctl[g]),
         .rem_i     (dv_rem[g]),
         .work_i    (dv_work[g]),
         .divisor_i (dv_div[g]),
         .ctl_o     (dv_ctl[g+1]),
         .rem_o     (dv_rem[g+1]),
         .work_o    (dv_work[g+1]),
         .divisor_o (dv_div[g+1])
      );
   end

   // ---------------- output register
   div_ctl_type       last_ctl;
   logic [FlowW-1:0]  quo;
   logic [FlowW-1:0]  flow_in;
   logic              out_valid_ff, out_ch_ff, out_err_ff;
   logic [FlowW-1:0]  out_flow_ff;

   assign last_ctl = dv_ctl[DivStages];
   assign quo      = dv_work[DivStages][FlowW-1:0];

   // drop the quotient on a bad frame or a zero word, apply sign otherwise
   always_comb begin
      if (last_ctl.force_zero) begin
         flow_in = '0;
      end else if (last_ctl.negative) begin
         flow_in = ~quo + 1'b1;
      end else begin
         flow_in = quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= last_ctl.valid;
      end
      out_ch_ff   <= last_ctl.channel;
      out_err_ff  <= last_ctl.crc_error;
      out_flow_ff <= flow_in;
   end

   assign rsp_strobe          = out_valid_ff;
   assign rsp_result_channel  = out_ch_ff;
   assign rsp_crc_error       = out_err_ff;
   assign rsp_flow_hundredths = out_flow_ff;

   // ---------------- checks
   `FSFD_ASSERT_SAME(a_err_gives_zero, clock, reset, rsp_strobe && rsp_crc_error, rsp_flow_hundredths == '0)
   `FSFD_ASSERT_NEXT(a_div_to_strobe, clock, reset, last_ctl.valid, rsp_strobe)
   `FSFD_ASSERT_SAME(a_rem_below_div, clock, reset, last_ctl.valid, dv_rem[DivStages] < dv_div[DivStages])

endmodule
